@@ rtl/ethernet_chunk_framer_crc32_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the chunk framer
// Shared property templates, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ETHERNET_CHUNK_FRAMER_CRC32_CORE_DEFINES_SVH
`define ETHERNET_CHUNK_FRAMER_CRC32_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ECF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ecf_pkg.sv @@
// ----------------------------------------------------------------------------
// Chunk framer package
// Types, constants and the CRC-32 byte update shared by the framer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ecf_pkg;

  // Chunk size including the four chunk-number bytes.
  localparam int unsigned ChunkBytes = 1460;
  localparam int unsigned PayloadMax = ChunkBytes - 4;
  localparam int unsigned CntW       = $clog2(PayloadMax + 1);

  // Header is dest MAC, source MAC and ethertype.
  localparam int unsigned HdrBytes = 14;
  localparam int unsigned HdrW     = 8 * HdrBytes;
  localparam int unsigned HdrIdxW  = $clog2(HdrBytes);

  // Command queue depth; must be a power of two.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcOnes = 32'hFFFF_FFFF;

  localparam logic [47:0] DestReset  = 48'h0050_56C0_0008;
  localparam logic [47:0] SrcReset   = 48'h0050_56C0_0008;
  localparam logic [15:0] TypeReset  = 16'h0800;
  localparam logic [30:0] FirstReset = 31'h0000_0000;
  localparam logic [30:0] LastReset  = 31'h7FFF_FFFF;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_DEST  = 3'd0,
    REG_SRC   = 3'd1,
    REG_TYPE  = 3'd2,
    REG_FIRST = 3'd3,
    REG_LAST  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_of_frame;
  } out_item_t;

  // Header fields that the back end serialises.
  typedef struct packed {
    logic [47:0] dest_address;
    logic [47:0] source_address;
    logic [15:0] frame_type;
  } hdr_cfg_t;

  // One queued command: what the back end must send for one input beat.
  typedef struct packed {
    logic        start;      // header and chunk number go first
    logic        has_byte;   // one payload byte
    logic        close;      // CRC follows
    logic [7:0]  data_byte;
    logic [31:0] chunk_num;
  } cmd_t;

  // Reflected CRC-32 update by one byte.
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ecf_front.sv @@
// ----------------------------------------------------------------------------
// Chunk framer front end
// Counts chunks and payload bytes, decides emission and queues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecf_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ecf_pkg::in_item_t in_data_i,
  input  wire logic [30:0]       first_chunk_i,
  input  wire logic [30:0]       last_chunk_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output ecf_pkg::cmd_t          cmd_o
);
  import ecf_pkg::*;

  logic [31:0]     ctr_q, ctr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            emit_q, emit_d;

  logic            accept;
  logic            start;
  logic            emit_eff;
  logic [CntW-1:0] cnt_inc;
  logic            full;
  logic            close;

  // A beat is taken whenever the queue has room, even if it queues nothing.
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the beat against the current chunk.
  always_comb begin
    start    = in_data_i.byte_valid && (cnt_q == '0);
    emit_eff = start ? ((ctr_q >= {1'b0, first_chunk_i}) && (ctr_q <= {1'b0, last_chunk_i}))
                     : emit_q;
    cnt_inc  = cnt_q + CntW'(in_data_i.byte_valid);
    full     = in_data_i.byte_valid && (cnt_inc >= CntW'(PayloadMax));
    close    = full || (in_data_i.end_of_file && (cnt_inc != '0));
  end

  assign push_o          = accept && emit_eff && (in_data_i.byte_valid || close);
  assign cmd_o.start     = start;
  assign cmd_o.has_byte  = in_data_i.byte_valid;
  assign cmd_o.close     = close;
  assign cmd_o.data_byte = in_data_i.data_byte;
  assign cmd_o.chunk_num = ctr_q;

  // Chunk state update.
  always_comb begin
    ctr_d  = ctr_q;
    cnt_d  = cnt_q;
    emit_d = emit_q;
    if (accept) begin
      if (full) begin
        ctr_d  = ctr_q + 32'd1;
        cnt_d  = '0;
        emit_d = 1'b0;
      end else begin
        cnt_d  = cnt_inc;
        emit_d = emit_eff;
      end
      if (in_data_i.end_of_file) begin
        ctr_d  = '0;
        cnt_d  = '0;
        emit_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q  <= '0;
      cnt_q  <= '0;
      emit_q <= 1'b0;
    end else begin
      ctr_q  <= ctr_d;
      cnt_q  <= cnt_d;
      emit_q <= emit_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ecf_fifo.sv @@
// ----------------------------------------------------------------------------
// Chunk framer command queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecf_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ecf_pkg::cmd_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               head_valid_o,
  output ecf_pkg::cmd_t      head_o
);
  import ecf_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o       = (cnt_q == QCntW'(QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Pointer and fill-level bookkeeping.
  always_comb begin
    wr_d  = do_push ? wr_q + QPtrW'(1) : wr_q;
    rd_d  = do_pop  ? rd_q + QPtrW'(1) : rd_q;
    cnt_d = cnt_q + QCntW'(do_push) - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ecf_back.sv @@
// ----------------------------------------------------------------------------
// Chunk framer back end
// Serialises header, chunk number, payload and CRC bytes into the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ethernet_chunk_framer_crc32_core_defines.svh"

module ecf_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ecf_pkg::hdr_cfg_t hdr_i,
  input  wire logic              head_valid_i,
  input  wire ecf_pkg::cmd_t     head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ecf_pkg::out_item_t     out_data_o
);
  import ecf_pkg::*;

  typedef enum logic [4:0] {
    S_NEXT = 5'b00001,
    S_HDR  = 5'b00010,
    S_NUM  = 5'b00100,
    S_DATA = 5'b01000,
    S_CRC  = 5'b10000
  } phase_e;

  phase_e             phase_q, phase_d;
  phase_e             cur_phase;
  logic [HdrIdxW-1:0] idx_q, idx_d;
  logic [31:0]        crc_q, crc_d;
  logic               out_valid_q;
  out_item_t          out_q;

  logic               fire;
  logic [HdrW-1:0]    hdr_vec;
  logic [HdrIdxW-1:0] hsel;
  logic [31:0]        crc_fin;
  logic [7:0]         byte_sel;
  logic               last_sel;
  logic               done;

  // A fresh command starts at its first phase.
  always_comb begin
    if (phase_q == S_NEXT) begin
      if (head_i.start) begin
        cur_phase = S_HDR;
      end else if (head_i.has_byte) begin
        cur_phase = S_DATA;
      end else begin
        cur_phase = S_CRC;
      end
    end else begin
      cur_phase = phase_q;
    end
  end

  assign fire    = head_valid_i && (!out_valid_q || out_ready_i);
  assign hdr_vec = {hdr_i.dest_address, hdr_i.source_address, hdr_i.frame_type};
  assign hsel    = HdrIdxW'(HdrBytes - 1) - idx_q;
  assign crc_fin = ~crc_q;

  // Byte selection, phase sequencing and CRC accumulation.
  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    crc_d    = crc_q;
    byte_sel = '0;
    last_sel = 1'b0;
    done     = 1'b0;
    unique case (cur_phase)
      S_HDR: begin
        byte_sel = hdr_vec[{hsel, 3'b000} +: 8];
        if (idx_q == HdrIdxW'(HdrBytes - 1)) begin
          phase_d = S_NUM;
          idx_d   = '0;
        end else begin
          phase_d = S_HDR;
          idx_d   = idx_q + HdrIdxW'(1);
        end
        if (idx_q == '0) begin
          crc_d = CrcOnes;
        end
      end
      S_NUM: begin
        byte_sel = head_i.chunk_num[{idx_q[1:0], 3'b000} +: 8];
        crc_d    = crc_byte(crc_q, byte_sel);
        if (idx_q[1:0] == 2'd3) begin
          phase_d = S_DATA;
          idx_d   = '0;
        end else begin
          idx_d   = idx_q + HdrIdxW'(1);
        end
      end
      S_DATA: begin
        byte_sel = head_i.data_byte;
        crc_d    = crc_byte(crc_q, byte_sel);
        idx_d    = '0;
        if (head_i.close) begin
          phase_d = S_CRC;
        end else begin
          done    = 1'b1;
        end
      end
      S_CRC: begin
        byte_sel = crc_fin[{idx_q[1:0], 3'b000} +: 8];
        if (idx_q[1:0] == 2'd3) begin
          last_sel = 1'b1;
          done     = 1'b1;
          crc_d    = CrcOnes;
        end else begin
          phase_d  = S_CRC;
          idx_d    = idx_q + HdrIdxW'(1);
        end
      end
      default: begin
        byte_sel = '0;
      end
    endcase
    if (done) begin
      phase_d = S_NEXT;
      idx_d   = '0;
    end
  end

  assign pop_o = fire && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= S_NEXT;
      idx_q       <= '0;
      crc_q       <= CrcOnes;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        crc_q   <= crc_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.frame_byte    <= byte_sel;
      out_q.last_of_frame <= last_sel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ECF_ASSERT_SAME(a_cmd_held, phase_q != S_NEXT, head_valid_i,
                   "command left the queue while still being sent")
  `ECF_ASSERT_NEXT(a_crc_end, fire && cur_phase == S_CRC && idx_q == HdrIdxW'(3),
                   phase_q == S_NEXT && crc_q == CrcOnes,
                   "frame did not end after the last CRC beat")
  `ECF_ASSERT_NEXT(a_crc_init, fire && cur_phase == S_HDR && idx_q == '0,
                   crc_q == CrcOnes, "CRC not seeded at frame start")

endmodule

`default_nettype wire

@@ rtl/ethernet_chunk_framer_crc32_core.sv @@
// ----------------------------------------------------------------------------
// Ethernet chunk framer with CRC-32
// Cuts a byte stream into numbered chunks and sends each in-range chunk as
// a frame with header, chunk number, payload and reflected CRC-32.
//
//   Channel  Direction  Handshake                Beat contents
//   in       input      in_valid_i / in_ready_o  data_byte, byte_valid, end_of_file
//   out      output     out_valid_o/out_ready_i  frame_byte, last_of_frame
//   cfg      input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// Mid-chunk payload beats pass at one per cycle while the output is ready.
// The first byte of an emitted chunk follows the header and chunk number,
// and a closing chunk adds the CRC bytes; the one-byte-per-cycle output serialiser sets this,
// and the two-entry command queue holds input beats off meanwhile.
// Reset is asynchronous, active low, and needs no clearing pass.
// A stalled output holds the serialiser; the input then stalls once the
// command queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ethernet_chunk_framer_crc32_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ecf_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ecf_pkg::out_item_t      out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [47:0]        cfg_data_i
);
  import ecf_pkg::*;

  hdr_cfg_t    hdr_q;
  logic [30:0] first_q;
  logic [30:0] last_q;

  logic        q_full;
  logic        push;
  cmd_t        push_cmd;
  logic        pop;
  logic        head_valid;
  cmd_t        head;

  // Configuration registers; every write beat is taken at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q.dest_address   <= DestReset;
      hdr_q.source_address <= SrcReset;
      hdr_q.frame_type     <= TypeReset;
      first_q              <= FirstReset;
      last_q               <= LastReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DEST:  hdr_q.dest_address   <= cfg_data_i;
        REG_SRC:   hdr_q.source_address <= cfg_data_i;
        REG_TYPE:  hdr_q.frame_type     <= cfg_data_i[15:0];
        REG_FIRST: first_q              <= cfg_data_i[30:0];
        REG_LAST:  last_q               <= cfg_data_i[30:0];
        default: begin
        end
      endcase
    end
  end

  ecf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .first_chunk_i (first_q),
    .last_chunk_i  (last_q),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  ecf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  ecf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hdr_i        (hdr_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the Ethernet chunk framer
// Streams file bytes through the framer and predicts every frame beat:
// header, little-endian chunk number, payload and reflected CRC-32. Covers
// partial chunks, end-of-file handling, range suppression, configuration
// changes between files and mid chunk, and random stalls on both channels.
// ----------------------------------------------------------------------------

module tb_top;
  import ecf_pkg::*;

  localparam int SettleCycles = 64;
  localparam int CycleLimit   = 500000;

  // How a generated file ends.
  typedef enum logic [1:0] {
    EOF_NONE,
    EOF_ON_BYTE,
    EOF_ALONE
  } eof_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  // Stimulus and expectation stores.
  in_item_t  file_items_q[$];
  out_item_t frame_beats_q[$];
  int        items_pushed = 0;
  int        items_taken = 0;
  int        mismatch_cnt = 0;
  int        cycle_cnt = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  bit        idle_en = 1'b1;
  out_item_t want;

  // Framer state as the testbench sees it.
  logic [47:0] mac_dest = DestReset;
  logic [47:0] mac_src = SrcReset;
  logic [15:0] eth_type = TypeReset;
  logic [30:0] range_first = FirstReset;
  logic [30:0] range_last = LastReset;
  logic [31:0] chunk_num = '0;
  int          chunk_fill = 0;
  logic [31:0] chunk_crc = '1;
  logic        chunk_sent = 1'b0;

  ethernet_chunk_framer_crc32_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Reflected CRC-32, one byte at a time, least significant bit first.
  function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic void add_beat(logic [7:0] b, logic last);
    out_item_t beat;
    beat.frame_byte    = b;
    beat.last_of_frame = last;
    frame_beats_q.push_back(beat);
  endfunction

  // Send the CRC if the chunk is in range, then move on to the next chunk.
  function automatic void close_chunk();
    logic [31:0] fin;
    fin = ~chunk_crc;
    if (chunk_sent) begin
      for (int i = 0; i < 4; i++) begin
        add_beat(fin[8*i +: 8], i == 3);
      end
    end
    chunk_num  = chunk_num + 32'd1;
    chunk_fill = 0;
    chunk_crc  = '1;
    chunk_sent = 1'b0;
  endfunction

  // Work out the frame beats caused by one accepted input beat.
  function automatic void predict_frame_beats(in_item_t it);
    if (it.byte_valid) begin
      if (chunk_fill == 0) begin
        chunk_sent = (chunk_num >= {1'b0, range_first}) && (chunk_num <= {1'b0, range_last});
        chunk_crc  = '1;
        if (chunk_sent) begin
          for (int i = 5; i >= 0; i--) add_beat(mac_dest[8*i +: 8], 1'b0);
          for (int i = 5; i >= 0; i--) add_beat(mac_src[8*i +: 8], 1'b0);
          add_beat(eth_type[15:8], 1'b0);
          add_beat(eth_type[7:0], 1'b0);
        end
        for (int i = 0; i < 4; i++) begin
          chunk_crc = crc32_step(chunk_crc, chunk_num[8*i +: 8]);
          if (chunk_sent) add_beat(chunk_num[8*i +: 8], 1'b0);
        end
      end
      chunk_crc = crc32_step(chunk_crc, it.data_byte);
      if (chunk_sent) add_beat(it.data_byte, 1'b0);
      chunk_fill++;
      if (chunk_fill >= PayloadMax) close_chunk();
    end
    if (it.end_of_file) begin
      if (chunk_fill > 0) close_chunk();
      chunk_num  = '0;
      chunk_fill = 0;
      chunk_crc  = '1;
      chunk_sent = 1'b0;
    end
  endfunction

  function automatic void queue_item(logic [7:0] d, logic v, logic e);
    in_item_t it;
    it.data_byte   = d;
    it.byte_valid  = v;
    it.end_of_file = e;
    file_items_q.push_back(it);
    items_pushed++;
  endfunction

  // A run of random bytes with the odd idle beat in between.
  function automatic void push_file(int n_bytes, eof_mode_e mode);
    for (int k = 0; k < n_bytes; k++) begin
      if ($urandom_range(0, 9) == 0) queue_item(8'($urandom), 1'b0, 1'b0);
      queue_item(8'($urandom), 1'b1, (mode == EOF_ON_BYTE) && (k == n_bytes - 1));
    end
    if (mode == EOF_ALONE) queue_item(8'($urandom), 1'b0, 1'b1);
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  // Register write over the configuration channel; only called while idle.
  task automatic write_reg(cfg_reg_e idx, logic [47:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DEST:  mac_dest = value;
      REG_SRC:   mac_src = value;
      REG_TYPE:  eth_type = value[15:0];
      REG_FIRST: range_first = value[30:0];
      REG_LAST:  range_last = value[30:0];
      default: ;
    endcase
  endtask

  // Hold off until every beat is taken, every frame beat has come out and
  // the framer has had time to finish any beat that sends nothing.
  task automatic wait_idle();
    @(posedge clk_i);
    while (items_taken != items_pushed) @(posedge clk_i);
    while (frame_beats_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Input driver: takes beats from the pending queue, with random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready_o) begin
        predict_frame_beats(in_data);
        items_taken++;
      end
      if (!in_valid || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
          in_gap   <= $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else if (file_items_q.size() != 0) begin
          in_data  <= file_items_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each frame beat and stalls at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_gap   <= 0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (frame_beats_q.size() == 0) begin
          $display("%0t: unexpected beat: expected none, actual byte %h last %b",
                   $time, out_data_o.frame_byte, out_data_o.last_of_frame);
          mismatch_cnt++;
        end else begin
          want = frame_beats_q.pop_front();
          if (out_data_o.frame_byte !== want.frame_byte) begin
            $display("%0t: frame_byte: expected %h, actual %h",
                     $time, want.frame_byte, out_data_o.frame_byte);
            mismatch_cnt++;
          end
          if (out_data_o.last_of_frame !== want.last_of_frame) begin
            $display("%0t: last_of_frame: expected %b, actual %b",
                     $time, want.last_of_frame, out_data_o.last_of_frame);
            mismatch_cnt++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap   <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        out_gap   <= $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    int start;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset header: idle beat, short chunk closed by a bare end of file,
    // an end of file on an empty chunk, and a one-byte file.
    queue_item(8'h3C, 1'b0, 1'b0);
    queue_item(8'h00, 1'b1, 1'b0);
    queue_item(8'hFF, 1'b1, 1'b0);
    queue_item(8'hA5, 1'b1, 1'b0);
    queue_item(8'hC3, 1'b0, 1'b0);
    queue_item(8'h00, 1'b0, 1'b1);
    queue_item(8'hFF, 1'b0, 1'b1);
    queue_item(8'h5A, 1'b1, 1'b1);
    wait_idle();

    // Extreme header values; leave a chunk open at the end.
    write_reg(REG_DEST, 48'h0);
    write_reg(REG_SRC, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_TYPE, 48'h0000_0000_FFFF);
    write_reg(REG_FIRST, 48'h0);
    write_reg(REG_LAST, 48'h0);
    queue_item(8'h81, 1'b1, 1'b0);
    queue_item(8'h7E, 1'b1, 1'b0);
    queue_item(8'h18, 1'b1, 1'b1);
    queue_item(8'h01, 1'b1, 1'b0);
    queue_item(8'h80, 1'b1, 1'b0);
    wait_idle();

    // Range and header move out from under the open chunk: it still closes
    // as a frame. The next two files are suppressed and the second is left open.
    write_reg(REG_FIRST, 48'h7FFF_FFFF);
    write_reg(REG_DEST, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_SRC, 48'h0);
    write_reg(REG_TYPE, 48'h0);
    queue_item(8'hF0, 1'b1, 1'b0);
    queue_item(8'h0F, 1'b0, 1'b1);
    queue_item(8'h55, 1'b1, 1'b0);
    queue_item(8'hAA, 1'b1, 1'b1);
    queue_item(8'h99, 1'b1, 1'b0);
    wait_idle();

    // Range opens mid chunk: the suppressed chunk stays suppressed.
    write_reg(REG_FIRST, 48'h0);
    write_reg(REG_LAST, 48'h7FFF_FFFF);
    queue_item(8'h66, 1'b1, 1'b1);
    wait_idle();

    // Inverted range sends nothing.
    write_reg(REG_FIRST, 48'h3);
    write_reg(REG_LAST, 48'h2);
    push_file(3, EOF_ALONE);
    wait_idle();

    // Random files under random settings; the last phase runs without idling.
    for (int ph = 0; ph < 4; ph++) begin
      idle_en = (ph < 3);
      write_reg(REG_DEST, rand48());
      write_reg(REG_SRC, rand48());
      write_reg(REG_TYPE, rand48());
      write_reg(REG_FIRST, ($urandom_range(0, 4) == 0) ? 48'($urandom) : 48'h0);
      write_reg(REG_LAST, ($urandom_range(0, 4) == 0) ? 48'($urandom_range(0, 1)) :
                          48'($urandom));
      start = items_pushed;
      while (items_pushed - start < 16) begin
        if ($urandom_range(0, 5) == 0) begin
          queue_item(8'($urandom), 1'b0, 1'($urandom));
        end
        push_file($urandom_range(1, 12), eof_mode_e'($urandom_range(0, 2)));
      end
      wait_idle();
    end

    if (mismatch_cnt == 0 && frame_beats_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
